// File: hdl/scba_pkg.sv
// Shared types and constants of the sprite cell blitter.
// Used by the channel interfaces, the divider, the multiplier and the top level.
// Depends on nothing.
package scba_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 16;
  localparam int PIX_W     = 32;
  localparam int CELL_W    = 8;
  localparam int POS_W     = 11;
  localparam int CNT_W     = 17;
  localparam int IDX_W     = 24;
  localparam int XPOS_W    = 12;
  localparam int LIM_W     = 18;
  localparam int MAC_A_W   = 20;
  localparam int MAC_B_W   = 9;
  localparam int MAC_P_W   = 30;

  localparam int GRID_MAX  = 256;
  localparam int SIZE_RST  = 256;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_R  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_C  = 3'd5;

  localparam logic [KIND_W-1:0] KIND_SHEET_WR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME_WR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

  localparam logic [7:0] ALPHA_ZERO = 8'h00;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  typedef struct packed {
    logic               start;
    logic [CFG_W-1:0]   dividend;
    logic [CFG_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [CFG_W-1:0]   quot;
  } div_res_t;

  typedef struct packed {
    logic signed [MAC_A_W-1:0] a;
    logic        [MAC_B_W-1:0] b;
    logic signed [MAC_P_W-1:0] c;
  } mac_op_t;

  function automatic logic [CFG_W-1:0] clamp_reg(logic [CFG_W-1:0] v, int unsigned hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > hi) begin
      r = CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hdl/scba_if.sv
// Valid/ready channel interfaces of the sprite cell blitter: item input and result output.
// Depends on scba_pkg for the field widths.
interface scba_in_if import scba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ADDR_W-1:0]        address;
  logic [PIX_W-1:0]         pixel_in;
  logic [CELL_W-1:0]        cell_row;
  logic [CELL_W-1:0]        cell_col;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;

  modport source (output valid, kind, address, pixel_in, cell_row, cell_col, pos_x, pos_y,
                  input ready);
  modport sink (input valid, kind, address, pixel_in, cell_row, cell_col, pos_x, pos_y,
                output ready);
endinterface

interface scba_out_if import scba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_out;
  logic              draw_done;
  logic [CNT_W-1:0]  written_count;

  modport source (output valid, pixel_out, draw_done, written_count, input ready);
  modport sink (input valid, pixel_out, draw_done, written_count, output ready);
endinterface

// File: hdl/sprite_cell_blit_alpha_blend.sv
// Top level of the sprite cell blitter: configuration, sequencer and pixel stores.
// Depends on scba_pkg, scba_if, scba_ram, scba_div and scba_mac.
//
// Usage: items arrive on req_i and results leave on rsp_o, each a valid/ready channel; a word
// moves at a clock edge where valid and ready are both high. A sheet or frame write gives no
// result; the next word is taken in the following cycle. A frame read gives its result after
// the read and done states. A draw computes the cell size by division and the addresses on the
// shared multiply-add unit, then walks the cell one pixel at a time; a blended pixel takes its
// color channels in turn, since the three color channels share one multiplier. While a read or
// draw is in progress req_i.ready is low. The result sits in an output register, so a new
// item is taken while rsp_o is stalled; a finished read or draw waits for that register to
// empty before returning to idle. Configuration is written through cfg_we_i; the user must
// write it only while the block is idle, which the block itself does not enforce. Reset
// returns the configuration registers to their defaults and empties the output register; the
// pixel stores are not cleared and must be written before they are read.
module sprite_cell_blit_alpha_blend import scba_pkg::*; #(
  parameter int MAX_FRAME_W = 256,
  parameter int MAX_FRAME_H = 256,
  parameter int MAX_SHEET_W = 256,
  parameter int MAX_SHEET_H = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  scba_in_if.sink              req_i,
  scba_out_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int SHEET_DEPTH = MAX_SHEET_W * MAX_SHEET_H;
  localparam int FRAME_DEPTH = MAX_FRAME_W * MAX_FRAME_H;
  localparam int SAW = $clog2(SHEET_DEPTH);
  localparam int FAW = $clog2(FRAME_DEPTH);

  localparam logic [CFG_W-1:0] FW_RST =
    CFG_W'((MAX_FRAME_W < SIZE_RST) ? MAX_FRAME_W : SIZE_RST);
  localparam logic [CFG_W-1:0] FH_RST =
    CFG_W'((MAX_FRAME_H < SIZE_RST) ? MAX_FRAME_H : SIZE_RST);
  localparam logic [CFG_W-1:0] SW_RST =
    CFG_W'((MAX_SHEET_W < SIZE_RST) ? MAX_SHEET_W : SIZE_RST);
  localparam logic [CFG_W-1:0] SH_RST =
    CFG_W'((MAX_SHEET_H < SIZE_RST) ? MAX_SHEET_H : SIZE_RST);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_DONE = 5'd2;
  localparam logic [4:0] S_CHK  = 5'd3;
  localparam logic [4:0] S_DIVW = 5'd4;
  localparam logic [4:0] S_DIVH = 5'd5;
  localparam logic [4:0] S_M1   = 5'd6;
  localparam logic [4:0] S_M2   = 5'd7;
  localparam logic [4:0] S_M3   = 5'd8;
  localparam logic [4:0] S_M4   = 5'd9;
  localparam logic [4:0] S_M5   = 5'd10;
  localparam logic [4:0] S_PIX  = 5'd11;
  localparam logic [4:0] S_PRD  = 5'd12;
  localparam logic [4:0] S_BL1  = 5'd13;
  localparam logic [4:0] S_BL2  = 5'd14;
  localparam logic [4:0] S_BLW  = 5'd15;
  localparam logic [4:0] S_NEXT = 5'd16;

  logic [4:0] state_q, state_d;

  logic [CFG_W-1:0] fw_q, fh_q, sw_q, sh_q, gr_q, gc_q;

  logic [CELL_W-1:0]       row_in_q, row_in_d, col_q, col_d;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d;
  logic                    rd_ok_q, rd_ok_d;
  logic [CFG_W-1:0]        cw_q, cw_d, ch_q, ch_d, i_q, i_d, j_q, j_d;
  logic [SAW-1:0]          base_q, base_d, row_sidx_q, row_sidx_d, sidx_q, sidx_d;
  logic signed [IDX_W-1:0] rowidx_q, rowidx_d;
  logic [LIM_W-1:0]        limit_q, limit_d;
  logic signed [XPOS_W-1:0] xpos_q, xpos_d;
  logic [FAW-1:0]          idx_q, idx_d;
  logic [PIX_W-1:0]        sp_q, sp_d, bg_q, bg_d;
  logic [23:0]             bl_q, bl_d;
  logic [1:0]              chan_q, chan_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [PIX_W-1:0]        res_pix_q, res_pix_d;
  logic                    res_draw_q, res_draw_d;

  logic                    out_valid_q, out_valid_d;
  logic [PIX_W-1:0]        out_pix_q;
  logic                    out_draw_q;
  logic [CNT_W-1:0]        out_cnt_q;

  logic                    acc, out_free, load_out;
  logic                    sheet_ok, frame_ok;
  logic signed [IDX_W-1:0] idx_w;
  logic                    idx_in;
  logic [CFG_W-1:0]        row_flip;
  logic [7:0]              alpha, inv_alpha, sp_inv;
  logic [15:0]             bsum;

  logic                    sheet_we;
  logic [SAW-1:0]          sheet_waddr;
  logic [PIX_W-1:0]        sheet_rdata;
  logic                    frame_we;
  logic [FAW-1:0]          frame_waddr, frame_raddr;
  logic [PIX_W-1:0]        frame_wdata, frame_rdata;

  div_req_t                div_req;
  div_res_t                div_res;
  mac_op_t                 mac_op;
  logic signed [MAC_P_W-1:0] p_q;

  scba_ram #(.WIDTH(PIX_W), .DEPTH(SHEET_DEPTH)) u_sheet (
    .clk_i   (clk_i),
    .we_i    (sheet_we),
    .waddr_i (sheet_waddr),
    .wdata_i (req_i.pixel_in),
    .raddr_i (sidx_q),
    .rdata_o (sheet_rdata)
  );

  scba_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frame_wdata),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  scba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  scba_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .p_o   (p_q)
  );

  assign acc       = req_i.valid & req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign load_out  = (state_q == S_DONE) && out_free;
  assign sheet_ok  = 32'(req_i.address) < 32'(SHEET_DEPTH);
  assign frame_ok  = 32'(req_i.address) < 32'(FRAME_DEPTH);
  assign sheet_waddr = SAW'(req_i.address);
  assign idx_w     = rowidx_q + IDX_W'(xpos_q);
  assign idx_in    = !idx_w[IDX_W-1] && (idx_w[IDX_W-2:0] < (IDX_W-1)'(limit_q));
  assign row_flip  = gr_q - CFG_W'(1) - {1'b0, row_in_q};
  assign alpha     = sheet_rdata[7:0];
  assign inv_alpha = ALPHA_FULL - alpha;
  assign sp_inv    = ALPHA_FULL - sp_q[7:0];
  // Exact floor division by 255 for sums up to 255 * 255.
  assign bsum      = p_q[15:0] + {8'b0, p_q[15:8]} + 16'd1;

  always_comb begin
    state_d     = state_q;
    row_in_d    = row_in_q;
    col_d       = col_q;
    px_d        = px_q;
    py_d        = py_q;
    rd_ok_d     = rd_ok_q;
    cw_d        = cw_q;
    ch_d        = ch_q;
    i_d         = i_q;
    j_d         = j_q;
    base_d      = base_q;
    row_sidx_d  = row_sidx_q;
    sidx_d      = sidx_q;
    rowidx_d    = rowidx_q;
    limit_d     = limit_q;
    xpos_d      = xpos_q;
    idx_d       = idx_q;
    sp_d        = sp_q;
    bg_d        = bg_q;
    bl_d        = bl_q;
    chan_d      = chan_q;
    cnt_d       = cnt_q;
    res_pix_d   = res_pix_q;
    res_draw_d  = res_draw_q;
    sheet_we    = 1'b0;
    frame_we    = 1'b0;
    frame_waddr = idx_q;
    frame_wdata = req_i.pixel_in;
    frame_raddr = idx_w[FAW-1:0];
    div_req     = '0;
    mac_op      = '0;

    unique case (state_q)
      S_IDLE: begin
        frame_raddr = FAW'(req_i.address);
        frame_waddr = FAW'(req_i.address);
        if (acc) begin
          unique case (req_i.kind)
            KIND_SHEET_WR: begin
              sheet_we = sheet_ok;
            end
            KIND_FRAME_WR: begin
              frame_we = frame_ok;
            end
            KIND_DRAW: begin
              row_in_d   = req_i.cell_row;
              col_d      = req_i.cell_col;
              px_d       = req_i.pos_x;
              py_d       = req_i.pos_y;
              cnt_d      = '0;
              res_pix_d  = '0;
              res_draw_d = 1'b1;
              state_d    = S_CHK;
            end
            KIND_READ: begin
              rd_ok_d    = frame_ok;
              cnt_d      = '0;
              res_draw_d = 1'b0;
              state_d    = S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        res_pix_d = rd_ok_q ? frame_rdata : '0;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CHK: begin
        if (({1'b0, row_in_q} >= gr_q) || ({1'b0, col_q} >= gc_q)) begin
          state_d = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = sw_q;
          div_req.divisor  = gc_q;
          state_d          = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_res.done) begin
          cw_d             = div_res.quot;
          div_req.start    = 1'b1;
          div_req.dividend = sh_q;
          div_req.divisor  = gr_q;
          state_d          = S_DIVH;
        end
      end
      S_DIVH: begin
        if (div_res.done) begin
          ch_d = div_res.quot;
          if ((cw_q == '0) || (div_res.quot == '0)) begin
            state_d = S_DONE;
          end else begin
            mac_op.a = MAC_A_W'(col_q);
            mac_op.b = cw_q;
            state_d  = S_M1;
          end
        end
      end
      S_M1: begin
        base_d   = SAW'(p_q);
        mac_op.a = MAC_A_W'(row_flip);
        mac_op.b = ch_q;
        state_d  = S_M2;
      end
      S_M2: begin
        mac_op.a = MAC_A_W'(p_q);
        mac_op.b = sw_q;
        mac_op.c = MAC_P_W'(base_q);
        state_d  = S_M3;
      end
      S_M3: begin
        base_d   = SAW'(p_q);
        mac_op.a = MAC_A_W'(py_q);
        mac_op.b = fw_q;
        state_d  = S_M4;
      end
      S_M4: begin
        rowidx_d = IDX_W'(p_q);
        mac_op.a = MAC_A_W'(fw_q);
        mac_op.b = fh_q;
        state_d  = S_M5;
      end
      S_M5: begin
        limit_d    = LIM_W'(p_q);
        i_d        = '0;
        j_d        = '0;
        sidx_d     = base_q;
        row_sidx_d = base_q;
        xpos_d     = XPOS_W'(px_q);
        state_d    = S_PIX;
      end
      S_PIX: begin
        if (idx_in) begin
          idx_d   = idx_w[FAW-1:0];
          state_d = S_PRD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_PRD: begin
        if (alpha == ALPHA_ZERO) begin
          state_d = S_NEXT;
        end else if (alpha == ALPHA_FULL) begin
          frame_we    = 1'b1;
          frame_wdata = sheet_rdata;
          cnt_d       = cnt_q + CNT_W'(1);
          state_d     = S_NEXT;
        end else begin
          sp_d     = sheet_rdata;
          bg_d     = frame_rdata;
          chan_d   = '0;
          mac_op.a = MAC_A_W'(frame_rdata[15:8]);
          mac_op.b = {1'b0, inv_alpha};
          state_d  = S_BL1;
        end
      end
      S_BL1: begin
        mac_op.a = MAC_A_W'(sp_q[8*chan_q+8 +: 8]);
        mac_op.b = {1'b0, sp_q[7:0]};
        mac_op.c = p_q;
        state_d  = S_BL2;
      end
      S_BL2: begin
        bl_d[8*chan_q +: 8] = bsum[15:8];
        if (chan_q == 2'd2) begin
          state_d = S_BLW;
        end else begin
          chan_d   = chan_q + 2'd1;
          mac_op.a = MAC_A_W'(bg_q[8*chan_q+16 +: 8]);
          mac_op.b = {1'b0, sp_inv};
          state_d  = S_BL1;
        end
      end
      S_BLW: begin
        frame_we    = 1'b1;
        frame_wdata = {bl_q, ALPHA_FULL};
        cnt_d       = cnt_q + CNT_W'(1);
        state_d     = S_NEXT;
      end
      S_NEXT: begin
        if (j_q == cw_q - CFG_W'(1)) begin
          if (i_q == ch_q - CFG_W'(1)) begin
            state_d = S_DONE;
          end else begin
            i_d        = i_q + CFG_W'(1);
            j_d        = '0;
            rowidx_d   = rowidx_q + IDX_W'(fw_q);
            xpos_d     = XPOS_W'(px_q);
            row_sidx_d = row_sidx_q + SAW'(sw_q);
            sidx_d     = row_sidx_q + SAW'(sw_q);
            state_d    = S_PIX;
          end
        end else begin
          j_d     = j_q + CFG_W'(1);
          xpos_d  = xpos_q + XPOS_W'(1);
          sidx_d  = sidx_q + SAW'(1);
          state_d = S_PIX;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fw_q        <= FW_RST;
      fh_q        <= FH_RST;
      sw_q        <= SW_RST;
      sh_q        <= SH_RST;
      gr_q        <= CFG_W'(1);
      gc_q        <= CFG_W'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FRAME_W: fw_q <= clamp_reg(cfg_wdata_i, MAX_FRAME_W);
          REG_FRAME_H: fh_q <= clamp_reg(cfg_wdata_i, MAX_FRAME_H);
          REG_SHEET_W: sw_q <= clamp_reg(cfg_wdata_i, MAX_SHEET_W);
          REG_SHEET_H: sh_q <= clamp_reg(cfg_wdata_i, MAX_SHEET_H);
          REG_GRID_R:  gr_q <= clamp_reg(cfg_wdata_i, GRID_MAX);
          REG_GRID_C:  gc_q <= clamp_reg(cfg_wdata_i, GRID_MAX);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_in_q   <= row_in_d;
    col_q      <= col_d;
    px_q       <= px_d;
    py_q       <= py_d;
    rd_ok_q    <= rd_ok_d;
    cw_q       <= cw_d;
    ch_q       <= ch_d;
    i_q        <= i_d;
    j_q        <= j_d;
    base_q     <= base_d;
    row_sidx_q <= row_sidx_d;
    sidx_q     <= sidx_d;
    rowidx_q   <= rowidx_d;
    limit_q    <= limit_d;
    xpos_q     <= xpos_d;
    idx_q      <= idx_d;
    sp_q       <= sp_d;
    bg_q       <= bg_d;
    bl_q       <= bl_d;
    chan_q     <= chan_d;
    cnt_q      <= cnt_d;
    res_pix_q  <= res_pix_d;
    res_draw_q <= res_draw_d;
    if (load_out) begin
      out_pix_q  <= res_pix_q;
      out_draw_q <= res_draw_q;
      out_cnt_q  <= cnt_q;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.pixel_out     = out_pix_q;
  assign rsp_o.draw_done     = out_draw_q;
  assign rsp_o.written_count = out_cnt_q;

`ifndef SYNTHESIS
  a_busy_after_long_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && ((req_i.kind == KIND_DRAW) || (req_i.kind == KIND_READ)) |=> !req_i.ready)
    else $error("ready stayed high after a read or draw was accepted");

  a_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.draw_done ? (rsp_o.pixel_out == '0) : (rsp_o.written_count == '0)))
    else $error("result carries fields of the wrong item kind");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> ((state_q == S_DIVW) || (state_q == S_DIVH)))
    else $error("divider finished outside the cell size setup");

  a_walk_in_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIX) |-> ((i_q < ch_q) && (j_q < cw_q)))
    else $error("cell walk left the cell");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !out_free |=> (state_q == S_DONE))
    else $error("result dropped while the output register was full");
`endif

endmodule

// File: hdl/scba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the sheet and the frame pixel stores.
module scba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/scba_div.sv
// Restoring divider for the cell size, one quotient bit per cycle.
// Depends on scba_pkg for the request and result structs.
module scba_div import scba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam int CW = $clog2(CFG_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CFG_W-1:0] quo_q, quo_d;
  logic [CFG_W-1:0] dvs_q, dvs_d;
  logic [CFG_W:0]   shifted;
  logic [CFG_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[CFG_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
      quo_d = {quo_q[CFG_W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(CFG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;

endmodule

// File: hdl/scba_mac.sv
// Shared multiply-add unit: p = a * b + c, registered, one result per cycle.
// Depends on scba_pkg for the operand struct.
module scba_mac import scba_pkg::*; (
  input  logic                      clk_i,
  input  mac_op_t                   op_i,
  output logic signed [MAC_P_W-1:0] p_o
);

  logic signed [MAC_P_W-1:0] p_q;
  logic signed [MAC_B_W:0]   b_ext;

  assign b_ext = {1'b0, op_i.b};

  always_ff @(posedge clk_i) begin
    p_q <= op_i.a * b_ext + op_i.c;
  end

  assign p_o = p_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for sprite_cell_blit_alpha_blend: preloads both pixel stores, then runs
// directed and random pixel loads, reads and cell draws against an in-bench image predictor.
// Depends on scba_pkg, the scba_in_if and scba_out_if channel interfaces, and the top level.
module tb;
  import scba_pkg::*;

  localparam int MAX_FRAME_W   = 256;
  localparam int MAX_FRAME_H   = 256;
  localparam int MAX_SHEET_W   = 256;
  localparam int MAX_SHEET_H   = 256;
  localparam int SHEET_DEPTH   = MAX_SHEET_W * MAX_SHEET_H;
  localparam int FRAME_DEPTH   = MAX_FRAME_W * MAX_FRAME_H;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000000;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [ADDR_W-1:0]       address;
    logic [PIX_W-1:0]        pixel;
    logic [CELL_W-1:0]       cell_row;
    logic [CELL_W-1:0]       cell_col;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } blit_item_t;

  typedef struct {
    logic [PIX_W-1:0] pixel_out;
    logic             draw_done;
    logic [CNT_W-1:0] written_count;
  } blit_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  scba_in_if  req_if ();
  scba_out_if rsp_if ();

  sprite_cell_blit_alpha_blend #(
    .MAX_FRAME_W(MAX_FRAME_W),
    .MAX_FRAME_H(MAX_FRAME_H),
    .MAX_SHEET_W(MAX_SHEET_W),
    .MAX_SHEET_H(MAX_SHEET_H)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  logic [PIX_W-1:0] sheet_img [SHEET_DEPTH];
  logic [PIX_W-1:0] frame_img [FRAME_DEPTH];
  int unsigned      geo_fw = MAX_FRAME_W;
  int unsigned      geo_fh = MAX_FRAME_H;
  int unsigned      geo_sw = MAX_SHEET_W;
  int unsigned      geo_sh = MAX_SHEET_H;
  int unsigned      geo_gr = 1;
  int unsigned      geo_gc = 1;

  blit_result_t awaited_rsp [$];
  int           mismatches;
  int           quiet_cycles;
  int           burst_left;
  bit           calm;
  bit           hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** sprite_cell_blit_alpha_blend: FAILED **");
    $finish;
  end

  function automatic int unsigned sat_reg(input logic [CFG_W-1:0] raw, input int unsigned top);
    if (raw == '0) begin
      return 1;
    end
    if (int'(raw) > top) begin
      return top;
    end
    return raw;
  endfunction

  function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] bg, sp);
    int unsigned      a;
    int unsigned      b;
    int unsigned      s;
    logic [PIX_W-1:0] mix;
    a = sp[7:0];
    mix = '0;
    mix[7:0] = ALPHA_FULL;
    for (int k = 1; k < 4; k++) begin
      b = bg[k*8 +: 8];
      s = sp[k*8 +: 8];
      mix[k*8 +: 8] = 8'((b * (255 - a) + s * a) / 255);
    end
    return mix;
  endfunction

  function automatic int unsigned blit_cell(input logic [CELL_W-1:0] row_in, col_in,
                                            input logic signed [POS_W-1:0] pos_x, pos_y);
    int unsigned      cw;
    int unsigned      ch;
    int unsigned      row;
    int unsigned      base;
    int unsigned      sidx;
    int unsigned      hits;
    int               ox;
    int               oy;
    int               fidx;
    int               span;
    logic [PIX_W-1:0] sp;
    cw = geo_sw / geo_gc;
    ch = geo_sh / geo_gr;
    ox = pos_x;
    oy = pos_y;
    span = int'(geo_fw * geo_fh);
    hits = 0;
    if (row_in >= geo_gr || col_in >= geo_gc || cw == 0 || ch == 0) begin
      return 0;
    end
    row = geo_gr - 1 - row_in;
    base = row * ch * geo_sw + col_in * cw;
    for (int i = 0; i < int'(ch); i++) begin
      for (int j = 0; j < int'(cw); j++) begin
        fidx = (oy + i) * int'(geo_fw) + (ox + j);
        sidx = base + i * geo_sw + j;
        if (fidx >= 0 && fidx < span && sidx < SHEET_DEPTH) begin
          sp = sheet_img[sidx];
          if (sp[7:0] == ALPHA_FULL) begin
            frame_img[fidx] = sp;
            hits++;
          end else if (sp[7:0] != ALPHA_ZERO) begin
            frame_img[fidx] = blend_px(frame_img[fidx], sp);
            hits++;
          end
        end
      end
    end
    return hits;
  endfunction

  task automatic apply_to_image(input blit_item_t it);
    blit_result_t r;
    case (it.kind)
      KIND_SHEET_WR: begin
        sheet_img[it.address] = it.pixel;
      end
      KIND_FRAME_WR: begin
        frame_img[it.address] = it.pixel;
      end
      KIND_DRAW: begin
        r.pixel_out = '0;
        r.draw_done = 1'b1;
        r.written_count = CNT_W'(blit_cell(it.cell_row, it.cell_col, it.pos_x, it.pos_y));
        awaited_rsp.push_back(r);
      end
      default: begin
        r.pixel_out = frame_img[it.address];
        r.draw_done = 1'b0;
        r.written_count = '0;
        awaited_rsp.push_back(r);
      end
    endcase
  endtask

  function automatic logic [PIX_W-1:0] sprite_px();
    logic [PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(0, 4))
      0: p[7:0] = ALPHA_ZERO;
      1: p[7:0] = ALPHA_FULL;
      2: p[7:0] = 8'd1;
      3: p[7:0] = 8'd254;
      default: ;
    endcase
    return p;
  endfunction

  function automatic blit_item_t item_of(input logic [KIND_W-1:0] kind, input int addr,
                                         input logic [PIX_W-1:0] pixel, input int row, col,
                                         input int px, py);
    blit_item_t it;
    it.kind = kind;
    it.address = ADDR_W'(addr);
    it.pixel = pixel;
    it.cell_row = CELL_W'(row);
    it.cell_col = CELL_W'(col);
    it.pos_x = POS_W'(px);
    it.pos_y = POS_W'(py);
    return it;
  endfunction

  function automatic blit_item_t random_item();
    blit_item_t  it;
    int unsigned cw;
    int unsigned ch;
    int unsigned sel;
    bit          aimed;
    cw = geo_sw / geo_gc;
    ch = geo_sh / geo_gr;
    it.address = $urandom;
    it.pixel = $urandom;
    it.cell_row = $urandom;
    it.cell_col = $urandom;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    sel = $urandom_range(0, 99);
    aimed = ($urandom_range(0, 7) != 0);
    if (sel < 15) begin
      it.kind = KIND_SHEET_WR;
      it.pixel = sprite_px();
      if (aimed) it.address = ADDR_W'($urandom_range(0, geo_sw * geo_sh - 1));
    end else if (sel < 30) begin
      it.kind = KIND_FRAME_WR;
      if (aimed) it.address = ADDR_W'($urandom_range(0, geo_fw * geo_fh - 1));
    end else if (sel < 55) begin
      it.kind = KIND_READ;
      if (aimed) it.address = ADDR_W'($urandom_range(0, geo_fw * geo_fh - 1));
    end else begin
      it.kind = KIND_DRAW;
      if (aimed) begin
        it.cell_row = CELL_W'($urandom_range(0, geo_gr - 1));
        it.cell_col = CELL_W'($urandom_range(0, geo_gc - 1));
        it.pos_x = POS_W'(int'($urandom_range(0, geo_fw + cw)) - int'(cw));
        it.pos_y = POS_W'(int'($urandom_range(0, geo_fh + ch)) - int'(ch));
      end
    end
    return it;
  endfunction

  task automatic send_item(input blit_item_t it);
    if (!calm && burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid    <= 1'b1;
    req_if.kind     <= it.kind;
    req_if.address  <= it.address;
    req_if.pixel_in <= it.pixel;
    req_if.cell_row <= it.cell_row;
    req_if.cell_col <= it.cell_col;
    req_if.pos_x    <= it.pos_x;
    req_if.pos_y    <= it.pos_y;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    apply_to_image(it);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_FRAME_W: geo_fw = sat_reg(val, MAX_FRAME_W);
      REG_FRAME_H: geo_fh = sat_reg(val, MAX_FRAME_H);
      REG_SHEET_W: geo_sw = sat_reg(val, MAX_SHEET_W);
      REG_SHEET_H: geo_sh = sat_reg(val, MAX_SHEET_H);
      REG_GRID_R:  geo_gr = sat_reg(val, GRID_MAX);
      REG_GRID_C:  geo_gc = sat_reg(val, GRID_MAX);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] fw, fh, sw, sh, gr, gc);
    wait_idle();
    write_reg(REG_FRAME_W, fw);
    write_reg(REG_FRAME_H, fh);
    write_reg(REG_SHEET_W, sw);
    write_reg(REG_SHEET_H, sh);
    write_reg(REG_GRID_R, gr);
    write_reg(REG_GRID_C, gc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : rsp_ready_gen
    int hold_left;
    int run_left;
    bit run_on;
    hold_left = 0;
    run_left = 0;
    run_on = 1'b1;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_on = !run_on;
          run_left = run_on ? $urandom_range(1, 10) : $urandom_range(1, 6);
        end
        run_left--;
        rsp_if.ready <= run_on;
      end
    end
  end

  initial begin : rsp_checker
    blit_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("unexpected result word: pixel_out %h draw_done %b written_count %0d",
                 rsp_if.pixel_out, rsp_if.draw_done, rsp_if.written_count);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_if.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %h, actual %h", want.pixel_out, rsp_if.pixel_out);
            mismatches++;
          end
          if (rsp_if.draw_done !== want.draw_done) begin
            $error("draw_done: expected %b, actual %b", want.draw_done, rsp_if.draw_done);
            mismatches++;
          end
          if (rsp_if.written_count !== want.written_count) begin
            $error("written_count: expected %0d, actual %0d",
                   want.written_count, rsp_if.written_count);
            mismatches++;
          end
        end
      end
    end
  end

  // Every entry of both stores is written first, so no later read sees an unwritten entry.
  task automatic test_preload();
    calm = 1'b1;
    for (int a = 0; a < SHEET_DEPTH; a++) begin
      send_item(item_of(KIND_SHEET_WR, a, sprite_px(), 0, 0, 0, 0));
    end
    for (int a = 0; a < FRAME_DEPTH; a++) begin
      send_item(item_of(KIND_FRAME_WR, a, $urandom, 0, 0, 0, 0));
    end
  endtask

  task automatic test_load_and_read();
    calm = 1'b0;
    send_item(item_of(KIND_FRAME_WR, 0, 32'h0000_0000, 0, 0, 0, 0));
    send_item(item_of(KIND_FRAME_WR, FRAME_DEPTH - 1, 32'hFFFF_FFFF, 255, 255, -1, -1));
    send_item(item_of(KIND_SHEET_WR, SHEET_DEPTH - 1, 32'hFFFF_FFFF, 0, 0, 0, 0));
    send_item(item_of(KIND_READ, FRAME_DEPTH - 1, 32'h0, 0, 0, 0, 0));
    send_item(item_of(KIND_READ, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
  endtask

  task automatic test_alpha_modes();
    set_geometry(4, 4, 4, 4, 4, 1);
    send_item(item_of(KIND_SHEET_WR, 0, {$urandom_range(0, 2**24 - 1), ALPHA_ZERO}, 0, 0, 0, 0));
    send_item(item_of(KIND_SHEET_WR, 1, {$urandom_range(0, 2**24 - 1), ALPHA_FULL}, 0, 0, 0, 0));
    send_item(item_of(KIND_SHEET_WR, 2, {$urandom_range(0, 2**24 - 1), 8'd1}, 0, 0, 0, 0));
    send_item(item_of(KIND_SHEET_WR, 3, {$urandom_range(0, 2**24 - 1), 8'd254}, 0, 0, 0, 0));
    for (int a = 0; a < 4; a++) begin
      send_item(item_of(KIND_FRAME_WR, a, $urandom, 0, 0, 0, 0));
    end
    send_item(item_of(KIND_DRAW, 0, 32'h0, 3, 0, 0, 0));
    for (int a = 0; a < 4; a++) begin
      send_item(item_of(KIND_READ, a, 32'h0, 0, 0, 0, 0));
    end
  endtask

  task automatic test_clipping();
    send_item(item_of(KIND_DRAW, 0, 32'h0, 3, 0, 2, 0));
    send_item(item_of(KIND_DRAW, 0, 32'h0, 3, 0, -2, 0));
    send_item(item_of(KIND_DRAW, 0, 32'h0, 3, 0, -1024, -1024));
    send_item(item_of(KIND_DRAW, 0, 32'h0, 0, 0, 1023, 1023));
    send_item(item_of(KIND_DRAW, 0, 32'h0, 4, 0, 0, 0));
    send_item(item_of(KIND_DRAW, 0, 32'h0, 255, 255, 0, 0));
    send_item(item_of(KIND_READ, 4, 32'h0, 0, 0, 0, 0));
    send_item(item_of(KIND_READ, 5, 32'h0, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_item(random_item());
    calm = 1'b0;
  endtask

  task automatic test_full_cell();
    set_geometry(256, 256, 256, 256, 1, 1);
    send_item(item_of(KIND_DRAW, 0, 32'h0, 0, 0, 0, 192));
    send_item(item_of(KIND_READ, 192 * 256, 32'h0, 0, 0, 0, 0));
  endtask

  task automatic random_traffic(input int n_items, input bit calm_phase);
    calm = calm_phase;
    repeat (n_items) send_item(random_item());
    calm = 1'b0;
  endtask

  task automatic test_random();
    set_geometry(256, 256, 64, 64, 8, 8);
    random_traffic(250, 1'b0);
    set_geometry(37, 23, 256, 256, 40, 32);
    random_traffic(200, 1'b1);
    set_geometry(0, 511, 17, 9, 3, 5);
    random_traffic(150, 1'b0);
    set_geometry(256, 1, 1, 1, 0, 1);
    random_traffic(150, 1'b0);
    set_geometry(256, 256, 256, 256, 300, 256);
    random_traffic(200, 1'b0);
    set_geometry(200, 100, 10, 16, 4, 20);
    random_traffic(100, 1'b0);
    set_geometry(256, 256, 32, 32, 4, 4);
    random_traffic(150, 1'b0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.address  = '0;
    req_if.pixel_in = '0;
    req_if.cell_row = '0;
    req_if.cell_col = '0;
    req_if.pos_x    = '0;
    req_if.pos_y    = '0;
    mismatches      = 0;
    burst_left      = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_preload();
    test_load_and_read();
    test_alpha_modes();
    test_clipping();
    test_backpressure();
    test_full_cell();
    test_random();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("** sprite_cell_blit_alpha_blend: PASSED **");
    end else begin
      $display("** sprite_cell_blit_alpha_blend: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/scba_pkg.sv
hdl/scba_if.sv
hdl/scba_ram.sv
hdl/scba_div.sv
hdl/scba_mac.sv
hdl/sprite_cell_blit_alpha_blend.sv
tb/tb.sv
